// ===== sv/wmce_pkg.sv =====
package wmce_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MAX_BURST = 63;

  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);
  localparam int unsigned BUF_AW = $clog2(MAX_BURST);
  localparam int unsigned CNT_W  = $clog2(MAX_BURST + 1);

  localparam logic [31:0] CMD_READ  = 32'd0;
  localparam logic [31:0] CMD_WRITE = 32'd1;
  localparam logic [31:0] CMD_MOVE  = 32'd2;

  localparam logic [31:0] STATUS_OK   = 32'd1;
  localparam logic [31:0] STATUS_FAIL = 32'd0;

  typedef enum logic [3:0] {
    PH_CLEAR,
    PH_OPCODE,
    PH_ADDR,
    PH_COUNT,
    PH_DATA,
    PH_DEST,
    PH_RD_ISSUE,
    PH_RD_WAIT,
    PH_WR_ISSUE,
    PH_WR_WAIT,
    PH_MV_READ,
    PH_MV_WRITE
  } phase_t;

endpackage

// ===== sv/wmce_ram.sv =====
module wmce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== sv/word_memory_command_engine.sv =====
// Command engine over a word store of MEM_WORDS 32-bit words.
// The input channel (in_word, in_valid, in_ready) carries a stream of words:
// an opcode (0 read, 1 write, 2 move), a byte address, a count, and then the
// data words of a write or the destination address of a move.
// The output channel (out_word, last_word, out_valid, out_ready) carries the
// status word (1 ok, 0 fail) and then read or echoed data; last_word marks the
// final transfer of an answer.
// Parsing takes one transfer per cycle while the output register is free. A
// read then fetches each word through the store's registered read port and
// sends it on. A write copies its burst word by word from the burst buffer to
// the store and echoes it, unless it holds a single word. A move copies word by
// word, reading then writing the store, so overlapping spans see each earlier
// copy. No input is taken while a burst or move walks memory. After reset the
// store is cleared to zero one word per cycle; in_ready stays low until it ends.
// A stalled receiver holds the output register, and in_ready stays low while
// an answer waits in it; read and echo words wait for the register as well.
module word_memory_command_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] in_word,
  input  logic               in_valid,
  output logic               in_ready,
  output logic signed [31:0] out_word,
  output logic               last_word,
  output logic               out_valid,
  input  logic               out_ready
);

  import wmce_pkg::*;

  phase_t              state, state_next;
  logic [1:0]          cmd, cmd_next;
  logic [31:0]         first_address, first_address_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                count_big, count_big_next;
  logic [CNT_W-1:0]    data_index, data_index_next;
  logic [CNT_W-1:0]    k, k_next;
  logic [MEM_AW-1:0]   base, base_next;
  logic [MEM_AW-1:0]   dest, dest_next;
  logic [MEM_AW-1:0]   clear_addr, clear_addr_next;
  logic                out_valid_next;
  logic [31:0]         out_word_next;
  logic                last_word_next;

  logic                st_we, st_re;
  logic [MEM_AW-1:0]   st_wa, st_ra;
  logic [31:0]         st_wd, st_rd;
  logic                bf_we, bf_re;
  logic [BUF_AW-1:0]   bf_wa, bf_ra;
  logic [31:0]         bf_wd, bf_rd;

  logic [31:0]         w;
  logic                accept, slot_free;
  logic                cnt_neg, cnt_big;
  logic [CNT_W-1:0]    cnt_val;
  logic [CNT_W-1:0]    di_inc;
  logic                k_last;

  function automatic logic span_ok(input logic [31:0] addr, input logic [CNT_W-1:0] n);
    logic [30:0] sum;
    sum = {1'b0, addr[31:2]} + 31'(n);
    return (addr[1:0] == 2'b00) && !addr[31] &&
           ({1'b0, addr[31:2]} < 31'(MEM_WORDS)) && (sum <= 31'(MEM_WORDS));
  endfunction

  wmce_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_store (
    .clk (clk),
    .we  (st_we),
    .wa  (st_wa),
    .wd  (st_wd),
    .re  (st_re),
    .ra  (st_ra),
    .rd  (st_rd)
  );

  wmce_ram #(.WIDTH(32), .DEPTH(MAX_BURST)) u_burst (
    .clk (clk),
    .we  (bf_we),
    .wa  (bf_wa),
    .wd  (bf_wd),
    .re  (bf_re),
    .ra  (bf_ra),
    .rd  (bf_rd)
  );

  assign w         = in_word;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = slot_free && (state == PH_OPCODE || state == PH_ADDR ||
                     state == PH_COUNT || state == PH_DATA || state == PH_DEST);
  assign accept    = in_valid && in_ready;
  assign cnt_neg   = w[31];
  assign cnt_big   = !w[31] && (w[30:0] > 31'(MAX_BURST));
  assign cnt_val   = cnt_neg ? '0 : w[CNT_W-1:0];
  assign di_inc    = data_index + CNT_W'(1);
  assign k_last    = (k == count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= PH_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
      out_valid  <= out_valid_next;
    end
    cmd           <= cmd_next;
    first_address <= first_address_next;
    count         <= count_next;
    count_big     <= count_big_next;
    data_index    <= data_index_next;
    k             <= k_next;
    base          <= base_next;
    dest          <= dest_next;
    out_word      <= out_word_next;
    last_word     <= last_word_next;
  end

  always_comb begin
    state_next         = state;
    cmd_next           = cmd;
    first_address_next = first_address;
    count_next         = count;
    count_big_next     = count_big;
    data_index_next    = data_index;
    k_next             = k;
    base_next          = base;
    dest_next          = dest;
    clear_addr_next    = clear_addr;
    out_valid_next     = out_valid && !out_ready;
    out_word_next      = out_word;
    last_word_next     = last_word;
    st_we = 1'b0;
    st_wa = '0;
    st_wd = '0;
    st_re = 1'b0;
    st_ra = '0;
    bf_we = 1'b0;
    bf_wa = '0;
    bf_wd = '0;
    bf_re = 1'b0;
    bf_ra = '0;

    case (state)
      PH_CLEAR: begin
        st_we           = 1'b1;
        st_wa           = clear_addr;
        clear_addr_next = clear_addr + MEM_AW'(1);
        if (clear_addr == MEM_AW'(MEM_WORDS - 1)) begin
          state_next = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        if (accept && (w == CMD_READ || w == CMD_WRITE || w == CMD_MOVE)) begin
          cmd_next   = w[1:0];
          state_next = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (accept) begin
          first_address_next = w;
          state_next         = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (accept) begin
          count_next     = cnt_val;
          count_big_next = cnt_big;
          state_next     = PH_OPCODE;
          if (cmd == CMD_MOVE[1:0]) begin
            state_next = PH_DEST;
          end else if (w == 32'd0 || cnt_neg) begin
            state_next = PH_OPCODE;
          end else if (cnt_big) begin
            out_valid_next = 1'b1;
            out_word_next  = STATUS_FAIL;
            last_word_next = 1'b1;
          end else if (cmd == CMD_WRITE[1:0]) begin
            data_index_next = '0;
            state_next      = PH_DATA;
          end else if (!span_ok(first_address, cnt_val)) begin
            out_valid_next = 1'b1;
            out_word_next  = STATUS_FAIL;
            last_word_next = 1'b1;
          end else begin
            out_valid_next = 1'b1;
            out_word_next  = STATUS_OK;
            last_word_next = 1'b0;
            base_next      = first_address[MEM_AW+1:2];
            k_next         = '0;
            state_next     = PH_RD_ISSUE;
          end
        end
      end
      PH_RD_ISSUE: begin
        st_re      = 1'b1;
        st_ra      = base + MEM_AW'(k);
        state_next = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_word_next  = st_rd;
          last_word_next = k_last;
          k_next         = k + CNT_W'(1);
          state_next     = k_last ? PH_OPCODE : PH_RD_ISSUE;
        end
      end
      PH_DATA: begin
        if (accept) begin
          bf_we           = 1'b1;
          bf_wa           = data_index[BUF_AW-1:0];
          bf_wd           = w;
          data_index_next = di_inc;
          if (di_inc == count) begin
            out_valid_next = 1'b1;
            if (!span_ok(first_address, count)) begin
              out_word_next  = STATUS_FAIL;
              last_word_next = 1'b1;
              state_next     = PH_OPCODE;
            end else begin
              out_word_next  = STATUS_OK;
              last_word_next = (count == CNT_W'(1));
              base_next      = first_address[MEM_AW+1:2];
              k_next         = '0;
              state_next     = PH_WR_ISSUE;
            end
          end
        end
      end
      PH_WR_ISSUE: begin
        bf_re      = 1'b1;
        bf_ra      = k[BUF_AW-1:0];
        state_next = PH_WR_WAIT;
      end
      PH_WR_WAIT: begin
        if (count == CNT_W'(1) || slot_free) begin
          st_we = 1'b1;
          st_wa = base + MEM_AW'(k);
          st_wd = bf_rd;
          if (count != CNT_W'(1)) begin
            out_valid_next = 1'b1;
            out_word_next  = bf_rd;
            last_word_next = k_last;
          end
          k_next     = k + CNT_W'(1);
          state_next = k_last ? PH_OPCODE : PH_WR_ISSUE;
        end
      end
      PH_DEST: begin
        if (accept) begin
          out_valid_next = 1'b1;
          last_word_next = 1'b1;
          state_next     = PH_OPCODE;
          if (count_big || !span_ok(first_address, count) || !span_ok(w, count)) begin
            out_word_next = STATUS_FAIL;
          end else begin
            out_word_next = STATUS_OK;
            base_next     = first_address[MEM_AW+1:2];
            dest_next     = w[MEM_AW+1:2];
            k_next        = '0;
            if (count != '0) begin
              state_next = PH_MV_READ;
            end
          end
        end
      end
      PH_MV_READ: begin
        st_re      = 1'b1;
        st_ra      = base + MEM_AW'(k);
        state_next = PH_MV_WRITE;
      end
      PH_MV_WRITE: begin
        st_we      = 1'b1;
        st_wa      = dest + MEM_AW'(k);
        st_wd      = st_rd;
        k_next     = k + CNT_W'(1);
        state_next = k_last ? PH_OPCODE : PH_MV_READ;
      end
      default: begin
        state_next = PH_OPCODE;
      end
    endcase
  end

  a_no_store_rw: assert property (@(posedge clk) disable iff (rst)
    !(st_we && st_re))
    else $error("store read and written in the same cycle");

  a_burst_in_range: assert property (@(posedge clk) disable iff (rst)
    bf_we |-> ({1'b0, bf_wa} < (BUF_AW + 1)'(MAX_BURST)))
    else $error("burst buffer write beyond its depth");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    state != PH_CLEAR |=> state != PH_CLEAR)
    else $error("clearing pass entered again after it ended");

  a_k_in_count: assert property (@(posedge clk) disable iff (rst)
    (state == PH_RD_WAIT || state == PH_WR_WAIT || state == PH_MV_WRITE) |-> k < count)
    else $error("word counter ran past the burst length");

  a_no_input_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == PH_RD_WAIT || state == PH_WR_WAIT || state == PH_MV_WRITE) |=>
      !$past(accept))
    else $error("input transfer taken while memory is being walked");

endmodule
